>>> sv/mmhh_pkg.sv
// Shared types and constants of the motor mode and heading-hold controller.
`default_nettype none

package mmhh_pkg;

  // Remote mode codes, same encoding on cmd_mode and active_mode
  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_HOLD   = 2'd1,
    MODE_MOOR   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Configuration register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_STEP_INTERVAL = 3'd0,
    REG_COOLDOWN      = 3'd1,
    REG_FAILSAFE      = 3'd2,
    REG_DEADBAND      = 3'd3,
    REG_SHORT_PULSE   = 3'd4,
    REG_MAX_TAP       = 3'd5
  } reg_idx_t;

  localparam int AddrW = 5;

  // Register reset values
  localparam logic [15:0] STEP_INTERVAL_RST = 16'd100;
  localparam logic [15:0] COOLDOWN_RST      = 16'd150;
  localparam logic [19:0] FAILSAFE_RST      = 20'd300000;
  localparam logic [11:0] DEADBAND_RST      = 12'd160;
  localparam logic [9:0]  SHORT_PULSE_RST   = 10'd60;
  localparam logic [6:0]  MAX_TAP_RST       = 7'd100;

  // Tick counter saturation points (CNT16/CNT20 one above the register maximum)
  localparam logic [16:0] CNT16_SAT   = 17'd65536;
  localparam logic [20:0] CNT20_SAT   = 21'd1048576;
  localparam logic [9:0]  ELAPSED_SAT = 10'd1023;

  // Heading geometry in 1/16 degree
  localparam logic signed [14:0] HALF_TURN = 15'sd2880;
  localparam logic signed [14:0] FULL_TURN = 15'sd5760;

  // Pulse length map: 80 + (deg - 15) * 44 / 9, divide by 9 as multiply by 7282 >> 16
  localparam logic [11:0] LONG_PULSE_MAG = 12'd240;
  localparam logic [7:0]  MAP_DEG_BASE   = 8'd15;
  localparam logic [9:0]  MAP_LEN_BASE   = 10'd80;
  localparam logic [12:0] RECIP_NINE     = 13'd7282;

  // Configuration bundle
  typedef struct packed {
    logic [15:0] step_interval_ms;
    logic [15:0] cooldown_ms;
    logic [19:0] failsafe_ms;
    logic [11:0] deadband_sixteenths;
    logic [9:0]  short_pulse_ms;
    logic [6:0]  max_tap;
  } cfg_t;

  // One input word
  typedef struct packed {
    logic        packet_valid;
    logic [1:0]  cmd_mode;
    logic        cmd_power;
    logic        cmd_up;
    logic        cmd_down;
    logic        cmd_left;
    logic        cmd_right;
    logic [12:0] boat_heading;
  } item_t;

  // One result word
  typedef struct packed {
    logic        power_pin;
    logic        left_pin;
    logic        right_pin;
    logic        step_up;
    logic        step_down;
    logic [6:0]  speed_tap;
    logic [1:0]  active_mode;
    logic [12:0] held_heading;
    logic        turn_active;
    logic        failsafe_active;
  } result_t;

endpackage

`default_nettype wire

>>> sv/motor_mode_heading_hold_ctrl.sv
// Top level of the motor mode and heading-hold controller.
//
//   channel   direction  handshake          payload
//   input     in         in_valid/in_stall  packet_valid, cmd_*, boat_heading
//   result    out        out_valid/out_stall power_pin .. failsafe_active
//   config    in/out     APB psel/penable   paddr, pwdata, prdata
//
// One word per cycle sustained while out_stall is low: input register, tick logic, result register.
// out_valid rises when a word moves on from the input register into the result register.
// The result register frees in the cycle it is taken, so a new word can enter
// while a finished word waits; out_stall backs up through in_stall.
// Synchronous reset clears all control state and loads the register defaults.
`default_nettype none

module motor_mode_heading_hold_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        packet_valid,
  input  wire logic [1:0]  cmd_mode,
  input  wire logic        cmd_power,
  input  wire logic        cmd_up,
  input  wire logic        cmd_down,
  input  wire logic        cmd_left,
  input  wire logic        cmd_right,
  input  wire logic [12:0] boat_heading,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             power_pin,
  output logic             left_pin,
  output logic             right_pin,
  output logic             step_up,
  output logic             step_down,
  output logic [6:0]       speed_tap,
  output logic [1:0]       active_mode,
  output logic [12:0]      held_heading,
  output logic             turn_active,
  output logic             failsafe_active,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  mmhh_pkg::cfg_t    cfg;
  mmhh_pkg::item_t   in_word;
  mmhh_pkg::result_t res;
  mmhh_pkg::result_t out_word;
  logic              in_full;
  logic              advance;

  mmhh_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Move a word forward when the result register is free or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word.packet_valid <= packet_valid;
      in_word.cmd_mode     <= cmd_mode;
      in_word.cmd_power    <= cmd_power;
      in_word.cmd_up       <= cmd_up;
      in_word.cmd_down     <= cmd_down;
      in_word.cmd_left     <= cmd_left;
      in_word.cmd_right    <= cmd_right;
      in_word.boat_heading <= boat_heading;
    end
  end

  mmhh_core u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (in_full && advance),
    .item (in_word),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (in_full && advance) begin
      out_word <= res;
    end
  end

  assign power_pin       = out_word.power_pin;
  assign left_pin        = out_word.left_pin;
  assign right_pin       = out_word.right_pin;
  assign step_up         = out_word.step_up;
  assign step_down       = out_word.step_down;
  assign speed_tap       = out_word.speed_tap;
  assign active_mode     = out_word.active_mode;
  assign held_heading    = out_word.held_heading;
  assign turn_active     = out_word.turn_active;
  assign failsafe_active = out_word.failsafe_active;

endmodule

`default_nettype wire

>>> sv/mmhh_regs.sv
// APB configuration register file of the heading-hold controller.
`default_nettype none

module mmhh_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [mmhh_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic      [31:0]               prdata,
  output logic                           pready,
  output mmhh_pkg::cfg_t                 cfg
);

  logic                    wr_en;
  mmhh_pkg::reg_idx_t      idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = mmhh_pkg::reg_idx_t'(paddr[4:2]);

  // Write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_interval_ms    <= mmhh_pkg::STEP_INTERVAL_RST;
      cfg.cooldown_ms         <= mmhh_pkg::COOLDOWN_RST;
      cfg.failsafe_ms         <= mmhh_pkg::FAILSAFE_RST;
      cfg.deadband_sixteenths <= mmhh_pkg::DEADBAND_RST;
      cfg.short_pulse_ms      <= mmhh_pkg::SHORT_PULSE_RST;
      cfg.max_tap             <= mmhh_pkg::MAX_TAP_RST;
    end else if (wr_en) begin
      unique case (idx)
        mmhh_pkg::REG_STEP_INTERVAL: cfg.step_interval_ms    <= pwdata[15:0];
        mmhh_pkg::REG_COOLDOWN:      cfg.cooldown_ms         <= pwdata[15:0];
        mmhh_pkg::REG_FAILSAFE:      cfg.failsafe_ms         <= pwdata[19:0];
        mmhh_pkg::REG_DEADBAND:      cfg.deadband_sixteenths <= pwdata[11:0];
        mmhh_pkg::REG_SHORT_PULSE:   cfg.short_pulse_ms      <= pwdata[9:0];
        mmhh_pkg::REG_MAX_TAP:       cfg.max_tap             <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      mmhh_pkg::REG_STEP_INTERVAL: prdata = {16'd0, cfg.step_interval_ms};
      mmhh_pkg::REG_COOLDOWN:      prdata = {16'd0, cfg.cooldown_ms};
      mmhh_pkg::REG_FAILSAFE:      prdata = {12'd0, cfg.failsafe_ms};
      mmhh_pkg::REG_DEADBAND:      prdata = {20'd0, cfg.deadband_sixteenths};
      mmhh_pkg::REG_SHORT_PULSE:   prdata = {22'd0, cfg.short_pulse_ms};
      mmhh_pkg::REG_MAX_TAP:       prdata = {25'd0, cfg.max_tap};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/mmhh_pulse_len.sv
// Steer pulse length from the heading error magnitude.
`default_nettype none

module mmhh_pulse_len (
  input  wire logic [11:0] mag,
  input  wire logic [9:0]  short_pulse_ms,
  output logic      [9:0]  len
);

  logic [7:0]  deg;
  logic [7:0]  deg_over;
  logic [12:0] scaled;
  logic [25:0] prod;

  // Whole degrees above fifteen, times 44 by shifts, then divide by 9
  assign deg      = mag[11:4];
  assign deg_over = deg - mmhh_pkg::MAP_DEG_BASE;
  assign scaled   = {deg_over, 5'b0} + {2'b0, deg_over, 3'b0} + {3'b0, deg_over, 2'b0};
  assign prod     = scaled * mmhh_pkg::RECIP_NINE;

  // Magnitude never exceeds 180 degrees, so the long length stays under 1023
  assign len = (mag < mmhh_pkg::LONG_PULSE_MAG) ? short_pulse_ms
             : mmhh_pkg::MAP_LEN_BASE + prod[25:16];

endmodule

`default_nettype wire

>>> sv/mmhh_core.sv
// Per-tick mode, steer, speed-tap and failsafe logic with its state.
`default_nettype none

module mmhh_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire mmhh_pkg::item_t  item,
  input  wire mmhh_pkg::cfg_t   cfg,
  output mmhh_pkg::result_t     res
);

  // State
  logic [1:0]  mode_reg;
  logic        c_power, c_up, c_down, c_left, c_right;
  logic        last_power;
  logic        pin_power, pin_left, pin_right;
  logic        req_up, req_down;
  logic [6:0]  tap_pos;
  logic [16:0] since_step;
  logic        nav_locked;
  logic [12:0] target_heading;
  logic        pulse_running;
  logic [9:0]  pulse_elapsed;
  logic [9:0]  pulse_length;
  logic [16:0] since_pulse_end;
  logic [20:0] since_packet;

  // Next values
  logic [1:0]  mode_reg_next;
  logic        c_power_next, c_up_next, c_down_next, c_left_next, c_right_next;
  logic        last_power_next;
  logic        pin_power_next, pin_left_next, pin_right_next;
  logic        req_up_next, req_down_next;
  logic [6:0]  tap_pos_next;
  logic [16:0] since_step_next;
  logic        nav_locked_next;
  logic [12:0] target_heading_next;
  logic        pulse_running_next;
  logic [9:0]  pulse_elapsed_next;
  logic [9:0]  pulse_length_next;
  logic [16:0] since_pulse_end_next;
  logic [20:0] since_packet_next;

  logic [16:0] ss_inc, spe_inc;
  logic [20:0] sp_inc;
  logic [9:0]  pe_inc;
  logic [12:0] nav_target;
  logic signed [14:0] err_raw, err;
  logic [14:0] err_abs;
  logic [11:0] mag;
  logic [9:0]  new_len;
  logic        did_up, did_down, fs;

  // Advance the tick counters
  assign ss_inc  = (since_step < mmhh_pkg::CNT16_SAT) ? since_step + 17'd1 : since_step;
  assign spe_inc = (since_pulse_end < mmhh_pkg::CNT16_SAT) ? since_pulse_end + 17'd1
                                                           : since_pulse_end;
  assign sp_inc  = (since_packet < mmhh_pkg::CNT20_SAT) ? since_packet + 21'd1 : since_packet;
  assign pe_inc  = (pulse_running && pulse_elapsed < mmhh_pkg::ELAPSED_SAT)
                   ? pulse_elapsed + 10'd1 : pulse_elapsed;

  // Wrap the heading error once to +-180 degrees
  assign nav_target = nav_locked ? target_heading : item.boat_heading;
  assign err_raw    = $signed({2'b00, nav_target}) - $signed({2'b00, item.boat_heading});
  always_comb begin
    err = err_raw;
    if (err_raw > mmhh_pkg::HALF_TURN) begin
      err = err_raw - mmhh_pkg::FULL_TURN;
    end else if (err_raw < -mmhh_pkg::HALF_TURN) begin
      err = err_raw + mmhh_pkg::FULL_TURN;
    end
  end
  assign err_abs = err[14] ? 15'(-err) : 15'(err);
  assign mag     = err_abs[11:0];

  mmhh_pulse_len u_pulse_len (
    .mag            (mag),
    .short_pulse_ms (cfg.short_pulse_ms),
    .len            (new_len)
  );

  // Tick update
  always_comb begin
    mode_reg_next        = mode_reg;
    c_power_next         = c_power;
    c_up_next            = c_up;
    c_down_next          = c_down;
    c_left_next          = c_left;
    c_right_next         = c_right;
    last_power_next      = last_power;
    pin_power_next       = pin_power;
    pin_left_next        = pin_left;
    pin_right_next       = pin_right;
    req_up_next          = req_up;
    req_down_next        = req_down;
    tap_pos_next         = tap_pos;
    since_step_next      = ss_inc;
    nav_locked_next      = nav_locked;
    target_heading_next  = target_heading;
    pulse_running_next   = pulse_running;
    pulse_elapsed_next   = pe_inc;
    pulse_length_next    = pulse_length;
    since_pulse_end_next = spe_inc;
    since_packet_next    = sp_inc;
    did_up               = 1'b0;
    did_down             = 1'b0;

    // Latch a new packet
    if (item.packet_valid) begin
      mode_reg_next     = item.cmd_mode;
      c_power_next      = item.cmd_power;
      c_up_next         = item.cmd_up;
      c_down_next       = item.cmd_down;
      c_left_next       = item.cmd_left;
      c_right_next      = item.cmd_right;
      since_packet_next = 21'd0;
      if (item.cmd_mode == mmhh_pkg::MODE_DIRECT || item.cmd_mode == mmhh_pkg::MODE_MOOR) begin
        nav_locked_next = 1'b0;
      end
    end

    // Power toggle and speed requests, shared by direct and hold modes
    if (mode_reg_next == mmhh_pkg::MODE_DIRECT || mode_reg_next == mmhh_pkg::MODE_HOLD) begin
      if (c_power_next != last_power) begin
        pin_power_next  = c_power_next;
        last_power_next = c_power_next;
      end
      if ((c_up_next && c_down_next) || !c_power_next) begin
        req_up_next   = 1'b0;
        req_down_next = 1'b0;
      end else begin
        req_up_next   = c_up_next;
        req_down_next = c_down_next;
      end
    end

    // Manual steering from the buttons; both held drops both
    if (mode_reg_next == mmhh_pkg::MODE_DIRECT) begin
      pin_left_next  = c_left_next && !c_right_next;
      pin_right_next = c_right_next && !c_left_next;
    end

    // Heading hold: lock target, start and end steer pulses
    if (mode_reg_next == mmhh_pkg::MODE_HOLD) begin
      if (!nav_locked_next) begin
        target_heading_next = item.boat_heading;
        nav_locked_next     = 1'b1;
      end
      if (!pulse_running && mag > cfg.deadband_sixteenths
          && since_pulse_end_next > {1'b0, cfg.cooldown_ms}) begin
        pulse_length_next  = new_len;
        pulse_elapsed_next = 10'd0;
        pulse_running_next = 1'b1;
        if (!err[14] && err != 15'sd0) begin
          pin_left_next = 1'b1;
        end else begin
          pin_right_next = 1'b1;
        end
      end
      if (pulse_running_next && pulse_elapsed_next >= pulse_length_next) begin
        pin_left_next        = 1'b0;
        pin_right_next       = 1'b0;
        pulse_running_next   = 1'b0;
        since_pulse_end_next = 17'd0;
      end
    end

    // Step the speed tap; a step up zeroes the interval so down cannot follow
    if (req_up_next && since_step_next > {1'b0, cfg.step_interval_ms}
        && tap_pos < cfg.max_tap) begin
      tap_pos_next    = tap_pos + 7'd1;
      since_step_next = 17'd0;
      did_up          = 1'b1;
    end else if (req_down_next && since_step_next > {1'b0, cfg.step_interval_ms}
                 && tap_pos != 7'd0) begin
      tap_pos_next    = tap_pos - 7'd1;
      since_step_next = 17'd0;
      did_down        = 1'b1;
    end

    // Failsafe forces all pins low
    fs = since_packet_next > {1'b0, cfg.failsafe_ms};
    if (fs) begin
      pin_power_next = 1'b0;
      pin_left_next  = 1'b0;
      pin_right_next = 1'b0;
    end
  end

  // Result word of this tick
  assign res.power_pin       = pin_power_next;
  assign res.left_pin        = pin_left_next;
  assign res.right_pin       = pin_right_next;
  assign res.step_up         = did_up;
  assign res.step_down       = did_down;
  assign res.speed_tap       = tap_pos_next;
  assign res.active_mode     = mode_reg_next;
  assign res.held_heading    = target_heading_next;
  assign res.turn_active     = pulse_running_next;
  assign res.failsafe_active = fs;

  // Hold state between words
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= mmhh_pkg::MODE_DIRECT;
      c_power         <= 1'b0;
      c_up            <= 1'b0;
      c_down          <= 1'b0;
      c_left          <= 1'b0;
      c_right         <= 1'b0;
      last_power      <= 1'b0;
      pin_power       <= 1'b0;
      pin_left        <= 1'b0;
      pin_right       <= 1'b0;
      req_up          <= 1'b0;
      req_down        <= 1'b0;
      tap_pos         <= 7'd0;
      since_step      <= 17'd0;
      nav_locked      <= 1'b0;
      target_heading  <= 13'd0;
      pulse_running   <= 1'b0;
      pulse_elapsed   <= 10'd0;
      pulse_length    <= 10'd0;
      since_pulse_end <= 17'd0;
      since_packet    <= 21'd0;
    end else if (go) begin
      mode_reg        <= mode_reg_next;
      c_power         <= c_power_next;
      c_up            <= c_up_next;
      c_down          <= c_down_next;
      c_left          <= c_left_next;
      c_right         <= c_right_next;
      last_power      <= last_power_next;
      pin_power       <= pin_power_next;
      pin_left        <= pin_left_next;
      pin_right       <= pin_right_next;
      req_up          <= req_up_next;
      req_down        <= req_down_next;
      tap_pos         <= tap_pos_next;
      since_step      <= since_step_next;
      nav_locked      <= nav_locked_next;
      target_heading  <= target_heading_next;
      pulse_running   <= pulse_running_next;
      pulse_elapsed   <= pulse_elapsed_next;
      pulse_length    <= pulse_length_next;
      since_pulse_end <= since_pulse_end_next;
      since_packet    <= since_packet_next;
    end
  end

endmodule

`default_nettype wire
